// ===== rtl/core/lwws_pkg.sv =====
// Shared types and constants for the LCD window write sequencer.
// Used by the front end, the item queue, the byte sequencer and the top level.
`default_nettype none

package lwws_pkg;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned SPAN_W  = 17;
  localparam int unsigned COUNT_W = 33;
  localparam int unsigned IDX_W   = 4;

  localparam logic [IDX_W-1:0] WIN_LAST = 4'd10;
  localparam logic [IDX_W-1:0] PIX_LAST = 4'd2;

  // Positions of the command bytes within a window sequence.
  localparam logic [15:0] WIN_CMD_MASK = 16'b0000_0100_0010_0001;

  typedef struct packed {
    logic                is_pixel;
    logic                done;
    logic [COORD_W-1:0]  xs;
    logic [COORD_W-1:0]  xe;
    logic [COORD_W-1:0]  ys;
    logic [COORD_W-1:0]  ye;
  } lwws_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lwws_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/lwws_front.sv =====
// Front end: accepts items, computes window spans and pixel count, and drops
// pixels with no open window. Depends on lwws_pkg.
`default_nettype none

module lwws_front
  import lwws_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                action,
  input  wire logic [COORD_W-1:0]  x_start,
  input  wire logic [COORD_W-1:0]  y_start,
  input  wire logic [COORD_W-1:0]  x_end,
  input  wire logic [COORD_W-1:0]  y_end,
  input  wire logic [COORD_W-1:0]  pixel,
  input  wire logic                q_full,
  output logic                     q_push,
  output lwws_entry_t              q_entry
);

  logic               s1_valid;
  lwws_entry_t        s1_entry;
  logic [SPAN_W-1:0]  s1_xspan;
  logic [SPAN_W-1:0]  s1_yspan;
  logic               s2_valid;
  lwws_entry_t        s2_entry;
  logic [SPAN_W-1:0]  s2_xspan;
  logic [SPAN_W-1:0]  s2_yspan;
  logic [COUNT_W-1:0] pixels_left;
  logic [COUNT_W-1:0] pixels_left_next;
  logic [2*SPAN_W-1:0] product;
  logic               drop;
  logic               s2_go;
  logic               s2_ready;
  logic               s1_ready;
  logic [SPAN_W-1:0]  xspan_in;
  logic [SPAN_W-1:0]  yspan_in;

  assign xspan_in = (x_end < x_start) ? '0
                  : ({1'b0, x_end} - {1'b0, x_start} + SPAN_W'(1));
  assign yspan_in = (y_end < y_start) ? '0
                  : ({1'b0, y_end} - {1'b0, y_start} + SPAN_W'(1));

  assign product  = (2*SPAN_W)'(s2_xspan) * (2*SPAN_W)'(s2_yspan);
  assign drop     = s2_entry.is_pixel && (pixels_left == '0);
  assign s2_go    = s2_valid && (drop || !q_full);
  assign s2_ready = !s2_valid || s2_go;
  assign s1_ready = !s1_valid || s2_ready;
  assign full     = !s1_ready;
  assign q_push   = s2_valid && !drop && !q_full;

  always_comb begin
    q_entry      = s2_entry;
    q_entry.done = s2_entry.is_pixel && (pixels_left == COUNT_W'(1));
  end

  always_comb begin
    pixels_left_next = pixels_left;
    if (s2_go) begin
      if (!s2_entry.is_pixel) begin
        pixels_left_next = product[COUNT_W-1:0];
      end else if (!drop) begin
        pixels_left_next = pixels_left - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      pixels_left <= '0;
    end else begin
      pixels_left <= pixels_left_next;
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s1_ready) begin
        s1_valid <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_entry <= s1_entry;
      s2_xspan <= s1_xspan;
      s2_yspan <= s1_yspan;
    end
    if (s1_ready) begin
      s1_entry.is_pixel <= action;
      s1_entry.done     <= 1'b0;
      s1_entry.xs       <= action ? pixel : x_start;
      s1_entry.xe       <= x_end;
      s1_entry.ys       <= y_start;
      s1_entry.ye       <= y_end;
      s1_xspan          <= xspan_in;
      s1_yspan          <= yspan_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lwws_queue.sv =====
// Short first-in first-out queue of classified items between front and back.
// Depends on lwws_pkg for the entry and status types.
`default_nettype none

module lwws_queue
  import lwws_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  lwws_entry_t       wr_data,
  input  wire logic         rd_en,
  output lwws_entry_t       rd_data,
  output lwws_qstat_t       stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lwws_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lwws_back.sv =====
// Back end: expands each queued item into its byte sequence, one byte per
// cycle while the output register is empty or being popped, into that output register. Depends on lwws_pkg.
`default_nettype none

module lwws_back
  import lwws_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  lwws_qstat_t       q_stat,
  input  lwws_entry_t       q_head,
  output logic              q_pop,
  input  wire logic         pop,
  output logic              empty,
  output logic [7:0]        out_byte,
  output logic              is_data,
  output logic              last,
  output logic              window_done
);

  logic             out_valid;
  logic             out_free;
  logic             cur_valid;
  lwws_entry_t      cur;
  logic [IDX_W-1:0] idx;
  logic             cur_final;
  logic             emit;
  logic [7:0]       win_bytes [16];
  logic [7:0]       pix_bytes [4];
  logic [7:0]       byte_sel;
  logic             data_sel;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win_bytes[i] = 8'h00;
    end
    win_bytes[0]  = CMD_COLUMN_SET;
    win_bytes[1]  = cur.xs[15:8];
    win_bytes[2]  = cur.xs[7:0];
    win_bytes[3]  = cur.xe[15:8];
    win_bytes[4]  = cur.xe[7:0];
    win_bytes[5]  = CMD_PAGE_SET;
    win_bytes[6]  = cur.ys[15:8];
    win_bytes[7]  = cur.ys[7:0];
    win_bytes[8]  = cur.ye[15:8];
    win_bytes[9]  = cur.ye[7:0];
    win_bytes[10] = CMD_MEMORY_WRITE;
    pix_bytes[0]  = {cur.xs[15:11], 3'b000};
    pix_bytes[1]  = {cur.xs[10:5], 2'b00};
    pix_bytes[2]  = {cur.xs[4:0], 3'b000};
    pix_bytes[3]  = 8'h00;
  end

  assign byte_sel  = cur.is_pixel ? pix_bytes[idx[1:0]] : win_bytes[idx];
  assign data_sel  = cur.is_pixel || !WIN_CMD_MASK[idx];
  assign cur_final = cur.is_pixel ? (idx == PIX_LAST) : (idx == WIN_LAST);
  assign out_free  = !out_valid || pop;
  assign emit      = cur_valid && out_free;
  assign q_pop     = !q_stat.empty && (!cur_valid || (emit && cur_final));
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (emit && cur_final) begin
        cur_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
      idx <= '0;
    end else if (emit) begin
      idx <= idx + IDX_W'(1);
    end
    if (emit) begin
      out_byte    <= byte_sel;
      is_data     <= data_sel;
      last        <= cur_final;
      window_done <= cur_final && cur.is_pixel && cur.done;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcd_window_write_sequencer_core.sv =====
// Top level of the LCD window write sequencer: front end, item queue, back end.
// Depends on lwws_pkg, lwws_front, lwws_queue and lwws_back.
// An accepted item passes through front-end stages s1 and s2, the queue and the back end's current-item register.
// Throughput: one byte per cycle while pop keeps the output free; a pixel is three bytes, a window eleven.
// Items enter every cycle until the queue fills; dropped pixels take no bytes.
// Reset clears the pixel count (no window open) and empties every stage.
`default_nettype none

module lcd_window_write_sequencer_core
  import lwws_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                action,
  input  wire logic [COORD_W-1:0]  x_start,
  input  wire logic [COORD_W-1:0]  y_start,
  input  wire logic [COORD_W-1:0]  x_end,
  input  wire logic [COORD_W-1:0]  y_end,
  input  wire logic [COORD_W-1:0]  pixel,
  output logic                     empty,
  input  wire logic                pop,
  output logic [7:0]               out_byte,
  output logic                     is_data,
  output logic                     last,
  output logic                     window_done
);

  logic        q_push;
  lwws_entry_t q_entry;
  logic        q_pop;
  lwws_entry_t q_head;
  lwws_qstat_t q_stat;

  lwws_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .action  (action),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .pixel   (pixel),
    .q_full  (q_stat.full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  lwws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_entry),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  lwws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .is_data     (is_data),
    .last        (last),
    .window_done (window_done)
  );

  a_done_on_last_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && window_done) |-> (last && is_data))
    else $error("window_done on a byte that is not a final data byte");

  a_cmd_bytes: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_data) |-> (!window_done && (last == (out_byte == CMD_MEMORY_WRITE))))
    else $error("command byte carries wrong flags");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !q_push)
    else $error("front end pushed into a full queue");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty)
    else $error("output not empty after reset");

endmodule

`default_nettype wire

// ===== tb/sv/tb_lcd_window_write_sequencer_core.sv =====
// Testbench for lcd_window_write_sequencer_core: drives window and pixel items through
// the push side, predicts the byte stream and checks every popped byte field by field.
// Depends on lwws_pkg and the RTL of the sequencer.

module tb_lcd_window_write_sequencer_core;
  import lwws_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 335;

  localparam logic ACT_WINDOW = 1'b0;
  localparam logic ACT_PIXEL  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [COORD_W-1:0] px;
  } lcd_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       last;
    logic       done;
  } lcd_byte_t;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic action;
  logic [COORD_W-1:0] x_start;
  logic [COORD_W-1:0] y_start;
  logic [COORD_W-1:0] x_end;
  logic [COORD_W-1:0] y_end;
  logic [COORD_W-1:0] pixel;
  logic empty;
  logic pop;
  logic [7:0] out_byte;
  logic is_data;
  logic last;
  logic window_done;

  lcd_item_t   pending_items[$];
  lcd_byte_t   expected_bytes[$];
  lcd_item_t   next_item;
  lcd_item_t   seen_item;
  lcd_byte_t   want;
  logic [COUNT_W-1:0] pixels_remaining;

  logic in_fire;
  int unsigned total_items;
  int unsigned n_accepted;
  int unsigned n_windows;
  int unsigned n_empty_windows;
  int unsigned n_pixels;
  int unsigned n_dropped;
  int unsigned n_bytes;
  int unsigned n_errors;
  int unsigned idle_cycles;
  int unsigned hold_left;
  logic        hold_done;

  lcd_window_write_sequencer_core u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .action(action),
    .x_start(x_start),
    .y_start(y_start),
    .x_end(x_end),
    .y_end(y_end),
    .pixel(pixel),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .is_data(is_data),
    .last(last),
    .window_done(window_done)
  );

  always #5 clk = ~clk;

  function automatic int unsigned send_idle_pct();
    if (n_accepted < total_items / 3) return 7;
    if (n_accepted < 2 * total_items / 3) return 53;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (n_accepted < total_items / 3) return 53;
    if (n_accepted < 2 * total_items / 3) return 7;
    return 0;
  endfunction

  function automatic void expect_byte(input logic [7:0] data, input logic data_flag,
                                      input logic last_flag, input logic done_flag);
    lcd_byte_t b;
    b.data = data;
    b.is_data = data_flag;
    b.last = last_flag;
    b.done = done_flag;
    expected_bytes.push_back(b);
  endfunction

  function automatic logic [SPAN_W-1:0] span_of(input logic [COORD_W-1:0] first,
                                                input logic [COORD_W-1:0] final_pos);
    if (final_pos < first) return '0;
    return {1'b0, final_pos} - {1'b0, first} + SPAN_W'(1);
  endfunction

  function automatic void predict_bytes(input lcd_item_t it);
    logic [2*SPAN_W-1:0] area;
    if (it.action == ACT_WINDOW) begin
      expect_byte(CMD_COLUMN_SET, 1'b0, 1'b0, 1'b0);
      expect_byte(it.xs[15:8], 1'b1, 1'b0, 1'b0);
      expect_byte(it.xs[7:0], 1'b1, 1'b0, 1'b0);
      expect_byte(it.xe[15:8], 1'b1, 1'b0, 1'b0);
      expect_byte(it.xe[7:0], 1'b1, 1'b0, 1'b0);
      expect_byte(CMD_PAGE_SET, 1'b0, 1'b0, 1'b0);
      expect_byte(it.ys[15:8], 1'b1, 1'b0, 1'b0);
      expect_byte(it.ys[7:0], 1'b1, 1'b0, 1'b0);
      expect_byte(it.ye[15:8], 1'b1, 1'b0, 1'b0);
      expect_byte(it.ye[7:0], 1'b1, 1'b0, 1'b0);
      expect_byte(CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b0);
      area = (2*SPAN_W)'(span_of(it.xs, it.xe)) * (2*SPAN_W)'(span_of(it.ys, it.ye));
      pixels_remaining = area[COUNT_W-1:0];
      n_windows++;
      if (pixels_remaining == '0) n_empty_windows++;
    end else if (pixels_remaining == '0) begin
      n_dropped++;
    end else begin
      pixels_remaining = pixels_remaining - COUNT_W'(1);
      expect_byte({it.px[15:11], 3'b000}, 1'b1, 1'b0, 1'b0);
      expect_byte({it.px[10:5], 2'b00}, 1'b1, 1'b0, 1'b0);
      expect_byte({it.px[4:0], 3'b000}, 1'b1, 1'b1, pixels_remaining == '0);
      n_pixels++;
    end
  endfunction

  task automatic add_window(input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                            input logic [COORD_W-1:0] xe, input logic [COORD_W-1:0] ye);
    lcd_item_t it;
    it.action = ACT_WINDOW;
    it.xs = xs;
    it.ys = ys;
    it.xe = xe;
    it.ye = ye;
    it.px = COORD_W'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic add_pixel(input logic [COORD_W-1:0] px);
    lcd_item_t it;
    it.action = ACT_PIXEL;
    it.xs = COORD_W'($urandom);
    it.ys = COORD_W'($urandom);
    it.xe = COORD_W'($urandom);
    it.ye = COORD_W'($urandom);
    it.px = px;
    pending_items.push_back(it);
  endtask

  // Item sender: an offered item stays on the ports until it is taken.
  always @(negedge clk) begin
    if (!rst && !(push && !in_fire)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        next_item = pending_items.pop_front();
        push <= 1'b1;
        action <= next_item.action;
        x_start <= next_item.xs;
        y_start <= next_item.ys;
        x_end <= next_item.xe;
        y_end <= next_item.ye;
        pixel <= next_item.px;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Byte receiver, with one long hold-off so the block backs up into its input.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      pop <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      in_fire = push && !full;
      if (in_fire) begin
        seen_item.action = action;
        seen_item.xs = x_start;
        seen_item.ys = y_start;
        seen_item.xe = x_end;
        seen_item.ye = y_end;
        seen_item.px = pixel;
        predict_bytes(seen_item);
        n_accepted++;
      end
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: out_byte %h is_data %b last %b window_done %b",
                 out_byte, is_data, last, window_done);
          n_errors++;
        end else begin
          want = expected_bytes.pop_front();
          n_bytes++;
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte);
            n_errors++;
          end
          if (is_data !== want.is_data) begin
            $error("is_data: expected %b, got %b", want.is_data, is_data);
            n_errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            n_errors++;
          end
          if (window_done !== want.done) begin
            $error("window_done: expected %b, got %b", want.done, window_done);
            n_errors++;
          end
        end
      end
      if (in_fire || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no item or byte moved for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n_live;
    int unsigned kind;
    int unsigned w;
    int unsigned h;
    int unsigned npix;
    int unsigned xs_r;
    int unsigned ys_r;
    int unsigned xe_r;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    action = ACT_WINDOW;
    x_start = '0;
    y_start = '0;
    x_end = '0;
    y_end = '0;
    pixel = '0;
    in_fire = 1'b0;
    pixels_remaining = '0;
    n_accepted = 0;
    n_windows = 0;
    n_empty_windows = 0;
    n_pixels = 0;
    n_dropped = 0;
    n_bytes = 0;
    n_errors = 0;
    idle_cycles = 0;
    hold_left = 0;
    hold_done = 1'b0;

    // Directed items: no-window pixel, single pixel window, color extremes,
    // reversed columns and rows, full-size window, window over an open window.
    add_pixel(16'hFFFF);
    add_window(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_pixel(16'hFFFF);
    add_pixel(16'h0000);
    add_window(16'h8001, 16'h7FFE, 16'h8002, 16'h7FFF);
    add_pixel(16'hF800);
    add_pixel(16'h07E0);
    add_pixel(16'h001F);
    add_pixel(16'hA5A5);
    add_window(16'h0005, 16'h0000, 16'h0004, 16'h000A);
    add_pixel(16'h1234);
    add_window(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    add_pixel(16'h4321);
    add_window(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    add_pixel(16'hFFFF);
    add_pixel(16'h0000);
    add_window(16'hFF00, 16'h00FF, 16'hFF00, 16'h0100);
    add_pixel(16'h5555);
    add_pixel(16'hAAAA);

    n_live = 0;
    while (n_live < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 3);
        xs_r = $urandom_range(0, 65536 - w);
        ys_r = $urandom_range(0, 65536 - h);
        add_window(COORD_W'(xs_r), COORD_W'(ys_r),
                   COORD_W'(xs_r + w - 1), COORD_W'(ys_r + h - 1));
        n_live++;
        npix = w * h;
        case ($urandom_range(9))
          0: npix = $urandom_range(0, w * h - 1);
          1: npix = w * h + $urandom_range(1, 2);
          default: ;
        endcase
        for (int i = 0; i < npix; i++) begin
          add_pixel(COORD_W'($urandom));
          if (i < w * h) n_live++;
        end
      end else if (kind < 80) begin
        xs_r = $urandom_range(1, 65535);
        xe_r = $urandom_range(0, xs_r - 1);
        if ($urandom_range(1)) begin
          add_window(COORD_W'(xs_r), COORD_W'($urandom), COORD_W'(xe_r),
                     COORD_W'($urandom));
        end else begin
          add_window(COORD_W'($urandom), COORD_W'(xs_r), COORD_W'($urandom),
                     COORD_W'(xe_r));
        end
        add_pixel(COORD_W'($urandom));
        n_live++;
      end else if (kind < 90) begin
        add_window(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom));
        npix = $urandom_range(1, 3);
        for (int i = 0; i < npix; i++) add_pixel(COORD_W'($urandom));
        n_live += 1 + npix;
      end else begin
        add_pixel(COORD_W'($urandom));
      end
    end
    total_items = pending_items.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || push || expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d windows (%0d empty), %0d pixels, %0d pixels dropped.",
             n_accepted, n_windows, n_empty_windows, n_pixels, n_dropped);
    $display("Checked %0d bytes with %0d mismatches.", n_bytes, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
